/* rtl/core/plt_pkg.sv */
// Shared types, constants and state codes for the polyline length tracker.
package plt_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int CAP_W     = 7;
    localparam int COUNT_O_W = 7;
    localparam int COORD_W   = 16;
    localparam int SEG_W     = 18;
    localparam int LEN_W     = 32;
    localparam int ROOT_W    = 18;
    localparam int SQ_IN_W   = 2 * ROOT_W;
    localparam int ABS_W     = COORD_W;
    localparam int SQ_W      = 2 * ABS_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                      action;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [COUNT_O_W-1:0] point_count;
        logic                 has_points;
        logic [LEN_W-1:0]     total_length;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SEG_W-1:0]   seg;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_DONE
    } state_t;

endpackage

/* rtl/core/plt_mem.sv */
// Point memory: one write port, one registered read port.
module plt_mem
    import plt_pkg::*;
#(
    parameter int DEPTH  = MAX_POINTS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/plt_sqrt.sv */
// Bit-serial truncated integer square root, one result bit per cycle.
module plt_sqrt
    import plt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SQ_IN_W-1:0] radicand,
    output logic               done,
    output logic [ROOT_W-1:0]  root
);

    localparam int REM_W  = ROOT_W + 2;
    localparam int STEP_W = $clog2(ROOT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_W - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SQ_IN_W-1:0] rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;

    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic               fits;
    logic [REM_W+1:0]   rem_diff;

    always_comb
    begin
        rem_sh   = {rem_reg, rad_reg[SQ_IN_W-1 -: 2]};
        trial    = {2'b00, root_reg, 2'b01};
        fits     = rem_sh >= trial;
        rem_diff = fits ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SQ_IN_W-3:0], 2'b00};
            rem_reg  <= rem_diff[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/core/polyline_length_tracker.sv */
// Polyline length tracker: point list control, length update and result register.
// Append to a non-empty list: read (S_FETCH), square (S_SQUARE), sum (S_SUM), then the
// 18-step bit-serial square root (S_ROOT) and S_DONE. Other items: read (S_FETCH), S_DONE.
// One item is in work at a time; the next is taken while a result waits.
// Reset clears count and length and sets capacity to 64; point memory is not cleared.
module polyline_length_tracker
    import plt_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_capacity,
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    state_t              state_reg;
    state_t              state_next;
    item_t               item_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [1:0]          status_reg;
    logic [ABS_W-1:0]    ax_reg;
    logic [ABS_W-1:0]    ay_reg;
    logic [SQ_W-1:0]     sqx_reg;
    logic [SQ_W-1:0]     sqy_reg;
    result_t             result_reg;
    logic                result_valid_reg;

    logic                mem_rd_en;
    logic                mem_wr_en;
    entry_t              mem_wr_data;
    entry_t              mem_rd_data;
    logic [CNT_W-1:0]    cnt_m1;
    logic                sq_start;
    logic                sq_done;
    logic [ROOT_W-1:0]   sq_root;
    logic [SQ_IN_W-1:0]  radicand;
    logic                load_result;

    logic [LIM_W-1:0]    cnt_ext;
    logic                is_full;
    logic                is_empty;
    logic                slot_free;
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [COORD_W:0]    adx;
    logic [COORD_W:0]    ady;
    logic [LEN_W:0]      len_sum;
    logic [LEN_W-1:0]    seg_ext;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        cnt_ext   = LIM_W'(count_reg);
        is_full   = (cnt_ext >= LIM_W'(cap_reg)) || (count_reg == CNT_MAX);
        is_empty  = (count_reg == '0);
        slot_free = !result_valid_reg || !result_stall;
        cnt_m1    = count_reg - 1'b1;

        dx  = $signed({item_reg.point_x[COORD_W-1], item_reg.point_x})
            - $signed({mem_rd_data.x[COORD_W-1], mem_rd_data.x});
        dy  = $signed({item_reg.point_y[COORD_W-1], item_reg.point_y})
            - $signed({mem_rd_data.y[COORD_W-1], mem_rd_data.y});
        adx = dx[COORD_W] ? 17'(-dx) : 17'(dx);
        ady = dy[COORD_W] ? 17'(-dy) : 17'(dy);

        radicand = SQ_IN_W'({1'b0, sqx_reg} + {1'b0, sqy_reg});
        len_sum  = {1'b0, len_reg} + LEN_W'(sq_root);
        seg_ext  = LEN_W'(mem_rd_data.seg);

        mem_wr_data.x   = item_reg.point_x;
        mem_wr_data.y   = item_reg.point_y;
        mem_wr_data.seg = (state_reg == S_ROOT) ? SEG_W'(sq_root) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        sq_start    = 1'b0;
        load_result = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    mem_rd_en  = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (item_reg.action == ACT_APPEND && !is_full && !is_empty)
                begin
                    state_next = S_SQUARE;
                end
                else
                begin
                    mem_wr_en  = (item_reg.action == ACT_APPEND) && !is_full;
                    state_next = S_DONE;
                end
            end
            S_SQUARE:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sq_start   = 1'b1;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (sq_done)
                begin
                    mem_wr_en  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    load_result = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            len_reg          <= '0;
            cap_reg          <= CAP_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_capacity;
            end

            if (state_reg == S_FETCH)
            begin
                if (item_reg.action == ACT_APPEND)
                begin
                    if (!is_full && is_empty)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                else if (!is_empty)
                begin
                    count_reg <= cnt_m1;
                    if (cnt_m1 == '0)
                    begin
                        len_reg <= '0;
                    end
                    else
                    begin
                        len_reg <= (len_reg > seg_ext) ? (len_reg - seg_ext) : '0;
                    end
                end
            end

            if (state_reg == S_ROOT && sq_done)
            begin
                count_reg <= count_reg + 1'b1;
                len_reg   <= len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
            end

            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end

        if (state_reg == S_FETCH)
        begin
            if (item_reg.action == ACT_APPEND && is_full)
            begin
                status_reg <= ST_FULL;
            end
            else if (item_reg.action == ACT_REMOVE && is_empty)
            begin
                status_reg <= ST_EMPTY;
            end
            else
            begin
                status_reg <= ST_OK;
            end
            ax_reg <= adx[ABS_W-1:0];
            ay_reg <= ady[ABS_W-1:0];
        end

        if (state_reg == S_SQUARE)
        begin
            sqx_reg <= ax_reg * ax_reg;
            sqy_reg <= ay_reg * ay_reg;
        end

        if (load_result)
        begin
            result_reg.status       <= status_reg;
            result_reg.point_count  <= cnt_ext[COUNT_O_W-1:0];
            result_reg.has_points   <= !is_empty;
            result_reg.total_length <= len_reg;
        end
    end

    plt_mem #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (cnt_m1[ADDR_W-1:0]),
        .rd_data (mem_rd_data)
    );

    plt_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (radicand),
        .done     (sq_done),
        .root     (sq_root)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("point count above memory depth");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (len_reg == '0))
        else $error("nonzero length with empty list");

    a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (count_reg < CNT_MAX))
        else $error("point write past memory depth");

    a_root_state: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_ROOT))
        else $error("square root finished outside root wait");

    a_sq_result: assert property (@(posedge clk) disable iff (!rst_n)
        sq_start |=> (state_reg == S_ROOT))
        else $error("square root started without wait state");

endmodule

/* tb/sv/polyline_length_tracker_tb.sv */
// Testbench for polyline_length_tracker: directed and random point lists checked against a model.
module polyline_length_tracker_tb;
    import plt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 60;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_capacity;
    logic             item_valid;
    logic             item_stall;
    item_t            item;
    logic             result_valid;
    logic             result_stall;
    result_t          result;

    polyline_length_tracker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_capacity (cfg_capacity),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // shadow of the point list
    logic signed [COORD_W-1:0] pts_x [MAX_POINTS_DEF];
    logic signed [COORD_W-1:0] pts_y [MAX_POINTS_DEF];
    logic [SEG_W-1:0]          seg_len [MAX_POINTS_DEF];
    int unsigned               pts_n;
    logic [LEN_W-1:0]          path_len;
    logic [CAP_W-1:0]          cap_reg;

    result_t expected_results[$];
    int      mismatch_count;
    bit      quiet;
    bit      sender_gaps;
    bit      hold_req;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [SEG_W-1:0] seg_root(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 18; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root[SEG_W-1:0];
    endfunction

    function automatic result_t track_point(item_t it);
        result_t         r;
        int unsigned     lim;
        int unsigned     p;
        longint          dx;
        longint          dy;
        longint unsigned ax;
        longint unsigned ay;
        logic [SEG_W-1:0] seg;
        longint unsigned sum;
        r.status = ST_OK;
        lim = (cap_reg > MAX_POINTS_DEF) ? MAX_POINTS_DEF : cap_reg;
        if (it.action == ACT_APPEND)
        begin
            if (pts_n >= lim || pts_n >= MAX_POINTS_DEF)
                r.status = ST_FULL;
            else
            begin
                seg = '0;
                if (pts_n > 0)
                begin
                    p   = pts_n - 1;
                    dx  = longint'(it.point_x) - longint'(pts_x[p]);
                    dy  = longint'(it.point_y) - longint'(pts_y[p]);
                    ax  = (dx < 0) ? -dx : dx;
                    ay  = (dy < 0) ? -dy : dy;
                    seg = seg_root(ax * ax + ay * ay);
                    sum = longint'(path_len) + seg;
                    path_len = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[LEN_W-1:0];
                end
                pts_x[pts_n]   = it.point_x;
                pts_y[pts_n]   = it.point_y;
                seg_len[pts_n] = seg;
                pts_n++;
            end
        end
        else
        begin
            if (pts_n == 0)
                r.status = ST_EMPTY;
            else
            begin
                p = pts_n - 1;
                if (p > 0)
                    path_len = (path_len > seg_len[p]) ? path_len - seg_len[p] : '0;
                pts_n = p;
                if (pts_n == 0)
                    path_len = '0;
            end
        end
        r.point_count  = pts_n[COUNT_O_W-1:0];
        r.has_points   = (pts_n != 0);
        r.total_length = path_len;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // result checker
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unrequested result", result.point_count, -1);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                    if (result.point_count !== want.point_count)
                        report_mismatch("point_count", result.point_count, want.point_count);
                    if (result.has_points !== want.has_points)
                        report_mismatch("has_points", result.has_points, want.has_points);
                    if (result.total_length !== want.total_length)
                        report_mismatch("total_length", result.total_length, want.total_length);
                end
            end
        end
    end

    // result side stall: random bursts, clear stretches, and one long hold-off on request
    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 40) == 0)
                repeat ($urandom_range(20, 80)) @(posedge clk);
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(input item_t it);
        if (sender_gaps && !quiet && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        expected_results.push_back(track_point(it));
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        cfg_valid    <= 1'b1;
        cfg_capacity <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_reg = cap;
    endtask

    function automatic item_t make_item(input logic act, input logic [15:0] x,
                                        input logic [15:0] y);
        item_t it;
        it.action  = act;
        it.point_x = x;
        it.point_y = y;
        return it;
    endfunction

    function automatic logic [15:0] pick_coord(input logic [15:0] near);
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1, 2, 3: return 16'($urandom);
            default: return near + 16'($urandom_range(0, 64)) - 16'd32;
        endcase
    endfunction

    task automatic run_walk(input int n_items, input int append_pct);
        item_t       it;
        logic [15:0] nx;
        logic [15:0] ny;
        for (int i = 0; i < n_items; i++)
        begin
            nx = (pts_n > 0) ? pts_x[pts_n-1] : '0;
            ny = (pts_n > 0) ? pts_y[pts_n-1] : '0;
            it = make_item(($urandom_range(1, 100) <= append_pct) ? ACT_APPEND : ACT_REMOVE,
                           pick_coord(nx), pick_coord(ny));
            send_item(it);
        end
    endtask

    // empty list, first point, extreme coordinates, removal down to nothing
    task automatic test_list_edges();
        send_item(make_item(ACT_REMOVE, 16'h1234, 16'h8765));
        send_item(make_item(ACT_APPEND, 16'h8000, 16'h8000));
        send_item(make_item(ACT_APPEND, 16'h7FFF, 16'h7FFF));
        send_item(make_item(ACT_APPEND, 16'h7FFF, 16'h8000));
        send_item(make_item(ACT_APPEND, 16'h8000, 16'h7FFF));
        send_item(make_item(ACT_REMOVE, 16'h7FFF, 16'h8000));
        send_item(make_item(ACT_REMOVE, 16'hFFFF, 16'h0000));
        send_item(make_item(ACT_REMOVE, 16'h0000, 16'hFFFF));
        send_item(make_item(ACT_REMOVE, 16'h5555, 16'hAAAA));
        send_item(make_item(ACT_REMOVE, 16'h8000, 16'h7FFF));
    endtask

    // capacity below count, one, zero and above the list size
    task automatic test_capacity_edges();
        send_item(make_item(ACT_APPEND, 16'h0000, 16'h0000));
        send_item(make_item(ACT_APPEND, 16'd48, 16'd64));
        send_item(make_item(ACT_APPEND, 16'd48, 16'd64));
        drain_results();
        write_capacity(7'd1);
        send_item(make_item(ACT_APPEND, 16'h0100, 16'h0100));
        send_item(make_item(ACT_REMOVE, 16'h0000, 16'h0000));
        send_item(make_item(ACT_REMOVE, 16'h0000, 16'h0000));
        send_item(make_item(ACT_APPEND, 16'h0200, 16'hFE00));
        send_item(make_item(ACT_REMOVE, 16'h0000, 16'h0000));
        send_item(make_item(ACT_APPEND, 16'hFFF0, 16'h0010));
        send_item(make_item(ACT_APPEND, 16'h0010, 16'hFFF0));
        drain_results();
        write_capacity(7'd0);
        send_item(make_item(ACT_REMOVE, 16'h0000, 16'h0000));
        send_item(make_item(ACT_APPEND, 16'h0001, 16'h0001));
        drain_results();
        write_capacity(7'd127);
        send_item(make_item(ACT_APPEND, 16'h0001, 16'h0001));
        send_item(make_item(ACT_APPEND, 16'hFFFF, 16'hFFFF));
    endtask

    // receiver holds off while the sender keeps offering; then the sender waits for all results
    task automatic test_output_hold();
        sender_gaps = 1'b0;
        hold_req    = 1'b1;
        run_walk(16, 70);
        drain_results();
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_walk();
        logic [CAP_W-1:0] caps [10];
        caps = '{7'd64, 7'd127, 7'd2, 7'd1, 7'($urandom_range(3, 12)), 7'd0,
                 7'd64, 7'd100, 7'($urandom_range(20, 63)), 7'd127};
        for (int ph = 0; ph < 10; ph++)
        begin
            write_capacity(caps[ph]);
            run_walk(130, (caps[ph] >= 64) ? 80 : $urandom_range(40, 85));
            drain_results();
        end
    endtask

    task automatic test_quiet_tail();
        quiet = 1'b1;
        write_capacity(7'd64);
        run_walk(150, 65);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_capacity <= '0;
        item_valid   <= 1'b0;
        item         <= '0;
        pts_n          = 0;
        path_len       = '0;
        cap_reg        = CAP_RESET;
        mismatch_count = 0;
        quiet          = 1'b0;
        sender_gaps    = 1'b1;
        hold_req       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_list_edges();
        test_capacity_edges();
        test_output_hold();
        test_random_walk();
        test_quiet_tail();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
